// ===== sv/cclc_pkg.sv =====
`default_nettype none

package cclc_pkg;

  // Default width of the running totals
  localparam int DEFAULT_COUNT_WIDTH = 32;
  // Width of each result field on the port
  localparam int OUT_W = 32;
  // Per-line separator counter width
  localparam int LINE_SEP_W = 16;

  // Byte codes the lexer reacts to
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef enum logic [6:0] {
    MODE_PLAIN  = 7'b0000001,
    MODE_STRING = 7'b0000010,
    MODE_CHAR   = 7'b0000100,
    MODE_SLASH  = 7'b0001000,
    MODE_BLOCK  = 7'b0010000,
    MODE_LINE   = 7'b0100000,
    MODE_STAR   = 7'b1000000
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       new_file;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] raw_lines;
    logic [OUT_W-1:0] code_lines;
    logic [OUT_W-1:0] comment_count;
    logic [OUT_W-1:0] separator_count;
  } out_beat_t;

  typedef struct packed {
    lex_mode_t             lex_mode;
    logic                  escape_pending;
    logic                  line_has_code;
    logic                  code_before_slash;
    logic [LINE_SEP_W-1:0] line_separators;
  } lex_state_t;

  typedef struct packed {
    logic line_end;
    logic code_line;
    logic comment_open;
  } lex_event_t;

  localparam lex_state_t LEX_RESET = '{
    lex_mode:          MODE_PLAIN,
    escape_pending:    1'b0,
    line_has_code:     1'b0,
    code_before_slash: 1'b0,
    line_separators:   '0
  };

  function automatic logic is_space(input logic [7:0] b);
    logic r;
    case (b) inside
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: r = 1'b1;
      default:                                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    return (b == CH_SEMI) || (b == CH_COMMA);
  endfunction

  // Modes in which a byte stays on the line
  function automatic logic mode_keeps(input lex_mode_t m);
    return !((m == MODE_BLOCK) || (m == MODE_LINE) || (m == MODE_STAR));
  endfunction

  // Plain, or any code that is not one of the other modes
  function automatic logic mode_is_plain(input lex_mode_t m);
    return !((m == MODE_STRING) || (m == MODE_CHAR) || (m == MODE_SLASH) ||
             (m == MODE_BLOCK) || (m == MODE_LINE) || (m == MODE_STAR));
  endfunction

endpackage

`default_nettype wire

// ===== sv/cclc_lex.sv =====
`default_nettype none

module cclc_lex (
  input  cclc_pkg::lex_state_t cur,
  input  logic [7:0]           source_byte,
  output cclc_pkg::lex_state_t nxt,
  output cclc_pkg::lex_event_t ev
);

  logic       keep_b;
  logic       tail_en;
  logic       drop_b;
  logic       end_b;
  logic [7:0] quote_b;

  always_comb begin
    nxt     = cur;
    ev      = '0;
    keep_b  = 1'b0;
    tail_en = 1'b0;
    drop_b  = 1'b0;
    end_b   = 1'b0;
    quote_b = (cur.lex_mode == cclc_pkg::MODE_STRING) ? cclc_pkg::CH_DQUOTE
                                                      : cclc_pkg::CH_SQUOTE;

    if (cur.escape_pending) begin
      // Take the escaped byte literally in the current mode
      nxt.escape_pending = 1'b0;
      if (source_byte == cclc_pkg::CH_LF) begin
        end_b = 1'b1;
      end else begin
        keep_b = 1'b1;
      end
    end else if (source_byte != cclc_pkg::CH_CR) begin
      tail_en = 1'b1;
      unique case (cur.lex_mode)
        cclc_pkg::MODE_STRING, cclc_pkg::MODE_CHAR: begin
          if (source_byte == quote_b) begin
            nxt.lex_mode = cclc_pkg::MODE_PLAIN;
          end else if (source_byte == cclc_pkg::CH_BSLASH) begin
            keep_b             = 1'b1;
            nxt.escape_pending = 1'b1;
            tail_en            = 1'b0;
          end
        end
        cclc_pkg::MODE_SLASH: begin
          if (source_byte == cclc_pkg::CH_STAR) begin
            nxt.lex_mode      = cclc_pkg::MODE_BLOCK;
            ev.comment_open   = 1'b1;
            nxt.line_has_code = cur.code_before_slash;
          end else if (source_byte == cclc_pkg::CH_SLASH) begin
            nxt.lex_mode      = cclc_pkg::MODE_LINE;
            ev.comment_open   = 1'b1;
            nxt.line_has_code = cur.code_before_slash;
          end else begin
            nxt.lex_mode = cclc_pkg::MODE_PLAIN;
          end
        end
        cclc_pkg::MODE_BLOCK: begin
          if (source_byte == cclc_pkg::CH_STAR) begin
            nxt.lex_mode = cclc_pkg::MODE_STAR;
          end
        end
        cclc_pkg::MODE_STAR: begin
          if (source_byte == cclc_pkg::CH_SLASH) begin
            nxt.lex_mode = cclc_pkg::MODE_PLAIN;
            drop_b       = 1'b1;
          end else if (source_byte != cclc_pkg::CH_STAR) begin
            nxt.lex_mode = cclc_pkg::MODE_BLOCK;
          end
        end
        cclc_pkg::MODE_LINE: begin
          if (source_byte == cclc_pkg::CH_LF) begin
            nxt.lex_mode = cclc_pkg::MODE_PLAIN;
          end
        end
        default: begin
          nxt.lex_mode = cclc_pkg::MODE_PLAIN;
          if (source_byte == cclc_pkg::CH_DQUOTE) begin
            nxt.lex_mode = cclc_pkg::MODE_STRING;
          end else if (source_byte == cclc_pkg::CH_SQUOTE) begin
            nxt.lex_mode = cclc_pkg::MODE_CHAR;
          end else if (source_byte == cclc_pkg::CH_SLASH) begin
            nxt.code_before_slash = cur.line_has_code;
            nxt.lex_mode          = cclc_pkg::MODE_SLASH;
          end else if (source_byte == cclc_pkg::CH_BSLASH) begin
            keep_b             = 1'b1;
            nxt.escape_pending = 1'b1;
            tail_en            = 1'b0;
          end
        end
      endcase

      if (tail_en) begin
        if (source_byte == cclc_pkg::CH_LF) begin
          end_b = 1'b1;
        end else if (!drop_b && cclc_pkg::mode_keeps(nxt.lex_mode)) begin
          keep_b = 1'b1;
        end
      end
    end

    if (keep_b) begin
      if (!cclc_pkg::is_space(source_byte)) begin
        nxt.line_has_code = 1'b1;
      end
      if (cclc_pkg::is_separator(source_byte) && (cur.line_separators != '1)) begin
        nxt.line_separators = cur.line_separators + 1'b1;
      end
    end

    // Close the line: the mode after this byte decides whether it was code
    if (end_b) begin
      ev.line_end           = 1'b1;
      ev.code_line          = cclc_pkg::mode_is_plain(nxt.lex_mode) && cur.line_has_code;
      nxt.line_has_code     = 1'b0;
      nxt.code_before_slash = 1'b0;
      nxt.line_separators   = '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/c_comment_strip_line_counter_unit.sv =====
`default_nettype none

// C comment stripper and source line counter.
// Input channel (in_valid / in_stall / in_data): one beat carries one source
// byte and a new_file flag; new_file clears the lexer and all totals before
// that byte is taken. Output channel (out_valid / out_stall / out_data): one
// beat per input beat with the running raw line, code line, comment and
// separator totals after that byte, each saturating at COUNT_WIDTH bits and
// shown as its low 32 bits.
// cfg_wr_en / cfg_wr_data write the separator count enable; it is sampled at
// the newline that ends each line.
// An accepted byte waits in the input register; its totals go to the result
// register. Throughput: one byte per cycle unless out_stall holds a result,
// set by the single lexer step between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers, returns the lexer
// to plain mode, clears the totals and the enable.
// While out_stall holds a result, one more byte can wait in the input
// register; in_stall rises only when both are full.
module c_comment_strip_line_counter_unit #(
  parameter int COUNT_WIDTH = cclc_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cclc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cclc_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  // Separator adds need room for the wider of the total and the line count
  localparam int SUM_W = ((COUNT_WIDTH > cclc_pkg::LINE_SEP_W) ? COUNT_WIDTH
                                                               : cclc_pkg::LINE_SEP_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SUM_W-1:0] CNT_MAX_EXT = {{(SUM_W-COUNT_WIDTH){1'b0}}, CNT_MAX};

  // Input register
  logic               s1_vld_r;
  cclc_pkg::in_beat_t s1_data_r;
  logic               s1_adv;

  // Lexer state and totals
  cclc_pkg::lex_state_t lex_r, lex_cur, lex_nxt;
  cclc_pkg::lex_event_t lex_ev;
  logic [COUNT_WIDTH-1:0] raw_r, code_r, cmt_r, sep_r;
  logic [COUNT_WIDTH-1:0] raw_cur, code_cur, cmt_cur, sep_cur;
  logic [COUNT_WIDTH-1:0] raw_nxt, code_nxt, cmt_nxt, sep_nxt;
  logic [SUM_W-1:0]       sep_sum;

  logic sep_en_r;

  // Result register
  logic                out_vld_r;
  cclc_pkg::out_beat_t out_data_r;
  cclc_pkg::out_beat_t out_data_nxt;

  // Advance the input beat whenever the result slot is free or being drained
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && out_vld_r && out_stall;

  // A new file starts from the reset state
  assign lex_cur  = s1_data_r.new_file ? cclc_pkg::LEX_RESET : lex_r;
  assign raw_cur  = s1_data_r.new_file ? '0 : raw_r;
  assign code_cur = s1_data_r.new_file ? '0 : code_r;
  assign cmt_cur  = s1_data_r.new_file ? '0 : cmt_r;
  assign sep_cur  = s1_data_r.new_file ? '0 : sep_r;

  cclc_lex u_lex (
    .cur         (lex_cur),
    .source_byte (s1_data_r.source_byte),
    .nxt         (lex_nxt),
    .ev          (lex_ev)
  );

  assign sep_sum = SUM_W'(sep_cur) + SUM_W'(lex_cur.line_separators);

  always_comb begin
    raw_nxt  = raw_cur;
    code_nxt = code_cur;
    cmt_nxt  = cmt_cur;
    sep_nxt  = sep_cur;
    if (lex_ev.line_end && (raw_cur != CNT_MAX)) begin
      raw_nxt = raw_cur + 1'b1;
    end
    if (lex_ev.code_line) begin
      if (code_cur != CNT_MAX) begin
        code_nxt = code_cur + 1'b1;
      end
      if (sep_en_r) begin
        sep_nxt = (sep_sum > CNT_MAX_EXT) ? CNT_MAX : sep_sum[COUNT_WIDTH-1:0];
      end
    end
    if (lex_ev.comment_open && (cmt_cur != CNT_MAX)) begin
      cmt_nxt = cmt_cur + 1'b1;
    end
  end

  // Truncate or zero-extend the totals to the port width
  always_comb begin
    out_data_nxt.raw_lines       = cclc_pkg::OUT_W'(raw_nxt);
    out_data_nxt.code_lines      = cclc_pkg::OUT_W'(code_nxt);
    out_data_nxt.comment_count   = cclc_pkg::OUT_W'(cmt_nxt);
    out_data_nxt.separator_count = cclc_pkg::OUT_W'(sep_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      lex_r     <= cclc_pkg::LEX_RESET;
      raw_r     <= '0;
      code_r    <= '0;
      cmt_r     <= '0;
      sep_r     <= '0;
      sep_en_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        lex_r     <= lex_nxt;
        raw_r     <= raw_nxt;
        code_r    <= code_nxt;
        cmt_r     <= cmt_nxt;
        sep_r     <= sep_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        sep_en_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // A code line is always also a raw line
  a_code_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    lex_ev.code_line |-> lex_ev.line_end)
    else $error("code line counted without a line end");

  // Code lines never outrun raw lines
  a_code_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
    code_r <= raw_r)
    else $error("code line total exceeds raw line total");

  // The raw line total only grows within one file
  a_raw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_data_r.new_file) |=> (raw_r >= $past(raw_r)))
    else $error("raw line total went down without a new file");

  // An escape is only armed from plain, string or char mode
  a_escape_mode: assert property (@(posedge clk) disable iff (!rst_n)
    lex_r.escape_pending |-> ((lex_r.lex_mode == cclc_pkg::MODE_PLAIN) ||
                              (lex_r.lex_mode == cclc_pkg::MODE_STRING) ||
                              (lex_r.lex_mode == cclc_pkg::MODE_CHAR)))
    else $error("escape pending in a comment or slash mode");

  // Each advanced beat lands in the result register
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced beat did not reach the result register");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;

  // Totals at the width the block is normally built with.
  localparam int CNT_W = cclc_pkg::DEFAULT_COUNT_WIDTH;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  // Cycles the receiver holds off during the back-pressure stretch.
  localparam int LONG_HOLD = 200;
  // Cycles with no beat on either channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let pass after the last expected beat.
  localparam int SETTLE = 4;
  localparam int RAND_CHUNKS = 11;
  localparam int CHUNK_LEN = 100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cclc_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  cclc_pkg::out_beat_t out_data;
  logic                cfg_wr_en;
  logic                cfg_wr_data;

  c_comment_strip_line_counter_unit #(
    .COUNT_WIDTH(CNT_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Running totals expected on the result channel, oldest first.
  cclc_pkg::out_beat_t totals_q[$];
  // Source text waiting to be sent by the random part.
  logic [7:0]          text_q[$];
  cclc_pkg::out_beat_t want;
  int                  mismatches = 0;
  int                  beat_no = 0;
  int                  quiet_cycles = 0;
  bit                  idle_on = 1'b0;
  bit                  long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of the mode, line flags and totals.
  // ---------------------------------------------------------------------------
  cclc_pkg::lex_mode_t cur_mode;
  logic                esc_armed;
  logic                line_code;
  logic                code_pre_slash;
  logic [15:0]         line_seps;
  logic [CNT_W-1:0]    raw_total;
  logic [CNT_W-1:0]    code_total;
  logic [CNT_W-1:0]    cmt_total;
  logic [CNT_W-1:0]    sep_total;
  logic                sep_enable;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input longint unsigned b);
    longint unsigned sum;
    sum = a;
    sum += b;
    return (sum > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(sum);
  endfunction

  function automatic void clear_lex();
    cur_mode       = cclc_pkg::MODE_PLAIN;
    esc_armed      = 1'b0;
    line_code      = 1'b0;
    code_pre_slash = 1'b0;
    line_seps      = '0;
    raw_total      = '0;
    code_total     = '0;
    cmt_total      = '0;
    sep_total      = '0;
  endfunction

  // Keep a byte on the current line: mark code, count separators.
  function automatic void keep_char(input logic [7:0] b);
    if (!(b inside {cclc_pkg::CH_SPACE, cclc_pkg::CH_TAB, cclc_pkg::CH_LF,
                    cclc_pkg::CH_VT, cclc_pkg::CH_FF, cclc_pkg::CH_CR}))
      line_code = 1'b1;
    if ((b == cclc_pkg::CH_SEMI || b == cclc_pkg::CH_COMMA) && line_seps != 16'hFFFF)
      line_seps++;
  endfunction

  function automatic void close_line();
    raw_total = sat_add(raw_total, 1);
    if (cur_mode == cclc_pkg::MODE_PLAIN && line_code) begin
      code_total = sat_add(code_total, 1);
      if (sep_enable)
        sep_total = sat_add(sep_total, line_seps);
    end
    line_code      = 1'b0;
    code_pre_slash = 1'b0;
    line_seps      = '0;
  endfunction

  // Enter a comment: drop only the opening slash from the line's code flag.
  function automatic void open_cmt(input cclc_pkg::lex_mode_t m);
    cur_mode  = m;
    cmt_total = sat_add(cmt_total, 1);
    line_code = code_pre_slash;
  endfunction

  // Advance the lexer by one byte and return the totals it leaves behind.
  function automatic cclc_pkg::out_beat_t lex_step(input logic [7:0] b, input logic nf);
    logic kept;
    logic done;
    kept = 1'b1;
    done = 1'b0;
    if (nf)
      clear_lex();
    if (esc_armed) begin
      // Take the escaped byte literally; an escaped newline still ends the line.
      esc_armed = 1'b0;
      if (b == cclc_pkg::CH_LF)
        close_line();
      else
        keep_char(b);
      done = 1'b1;
    end else if (b == cclc_pkg::CH_CR) begin
      done = 1'b1;
    end else begin
      case (cur_mode)
        cclc_pkg::MODE_STRING, cclc_pkg::MODE_CHAR: begin
          if (b == ((cur_mode == cclc_pkg::MODE_STRING) ? cclc_pkg::CH_DQUOTE
                                                         : cclc_pkg::CH_SQUOTE)) begin
            cur_mode = cclc_pkg::MODE_PLAIN;
          end else if (b == cclc_pkg::CH_BSLASH) begin
            keep_char(b);
            esc_armed = 1'b1;
            done = 1'b1;
          end
        end
        cclc_pkg::MODE_SLASH: begin
          if (b == cclc_pkg::CH_STAR)
            open_cmt(cclc_pkg::MODE_BLOCK);
          else if (b == cclc_pkg::CH_SLASH)
            open_cmt(cclc_pkg::MODE_LINE);
          else
            cur_mode = cclc_pkg::MODE_PLAIN;
        end
        cclc_pkg::MODE_BLOCK: begin
          if (b == cclc_pkg::CH_STAR)
            cur_mode = cclc_pkg::MODE_STAR;
        end
        cclc_pkg::MODE_STAR: begin
          if (b == cclc_pkg::CH_SLASH) begin
            cur_mode = cclc_pkg::MODE_PLAIN;
            kept = 1'b0;
          end else if (b != cclc_pkg::CH_STAR) begin
            cur_mode = cclc_pkg::MODE_BLOCK;
          end
        end
        cclc_pkg::MODE_LINE: begin
          if (b == cclc_pkg::CH_LF)
            cur_mode = cclc_pkg::MODE_PLAIN;
        end
        default: begin
          cur_mode = cclc_pkg::MODE_PLAIN;
          if (b == cclc_pkg::CH_DQUOTE) begin
            cur_mode = cclc_pkg::MODE_STRING;
          end else if (b == cclc_pkg::CH_SQUOTE) begin
            cur_mode = cclc_pkg::MODE_CHAR;
          end else if (b == cclc_pkg::CH_SLASH) begin
            code_pre_slash = line_code;
            cur_mode = cclc_pkg::MODE_SLASH;
          end else if (b == cclc_pkg::CH_BSLASH) begin
            keep_char(b);
            esc_armed = 1'b1;
            done = 1'b1;
          end
        end
      endcase
      if (!done) begin
        if (b == cclc_pkg::CH_LF)
          close_line();
        else if (kept && cur_mode inside {cclc_pkg::MODE_PLAIN, cclc_pkg::MODE_STRING,
                                          cclc_pkg::MODE_CHAR, cclc_pkg::MODE_SLASH})
          keep_char(b);
      end
    end
    return '{raw_lines:       32'(raw_total),
             code_lines:      32'(code_total),
             comment_count:   32'(cmt_total),
             separator_count: 32'(sep_total)};
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the block takes it, then predict its totals.
  task automatic send_byte(input logic [7:0] b, input logic nf);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{source_byte: b, new_file: nf};
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    totals_q.push_back(lex_step(b, nf));
  endtask

  task automatic send_text(input string s, input logic nf_first);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], (i == 0) ? nf_first : 1'b0);
  endtask

  // Drop valid, wait for every expected beat, then let the block settle.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (totals_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the separator enable; only called with nothing in flight.
  task automatic write_sep_enable(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sep_enable = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat %0d: %s expected %0d, got %0d", beat_no, name, want_v, got_v);
    end
  endtask

  // Compare each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (totals_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: result arrived with no totals expected", beat_no);
      end else begin
        want = totals_q.pop_front();
        check_field("raw_lines", want.raw_lines, out_data.raw_lines);
        check_field("code_lines", want.code_lines, out_data.code_lines);
        check_field("comment_count", want.comment_count, out_data.comment_count);
        check_field("separator_count", want.separator_count, out_data.separator_count);
      end
      beat_no++;
    end
  end

  // Abandon the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short walk through the lexer's corners with the enable at its reset value:
  // code before a comment, star runs before the close, a slash that opens
  // nothing, escaped carriage return and newline, escaped quote in a char
  // literal, newline inside a string, a line comment after code, blank bytes
  // of every kind, and NUL and 0xFF as code.
  task automatic test_directed_cases();
    send_text("a/*b**/;/x\\\015\n'\\'',\n\"s\n\\\n\",//c\n", 1'b1);
    send_byte(cclc_pkg::CH_TAB, 1'b1);
    send_byte(cclc_pkg::CH_VT, 1'b0);
    send_byte(cclc_pkg::CH_FF, 1'b0);
    send_byte(cclc_pkg::CH_SPACE, 1'b0);
    send_byte(cclc_pkg::CH_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(cclc_pkg::CH_LF, 1'b0);
    wait_all_results();
  endtask

  // Toggle the separator enable between lines and in the middle of one.
  task automatic test_separator_enable();
    send_text("a;,\n", 1'b1);
    wait_all_results();
    write_sep_enable(1'b1);
    send_text("b;,;", 1'b0);
    wait_all_results();
    write_sep_enable(1'b0);
    write_sep_enable(1'b1);
    send_text("\nx\";\"\n", 1'b0);
    wait_all_results();
    write_sep_enable(1'b0);
    send_text("c;\n", 1'b0);
    wait_all_results();
    write_sep_enable(1'b1);
  endtask

  // Run up the totals with many short code lines that end in a line comment,
  // then one long line of separators.
  task automatic test_line_totals();
    for (int i = 0; i < 100; i++)
      send_text(";//\n", i == 0);
    for (int i = 0; i < 150; i++)
      send_byte(cclc_pkg::CH_COMMA, i == 0);
    send_byte(cclc_pkg::CH_LF, 1'b0);
    wait_all_results();
  endtask

  // Queue one random token of C-like text; a few are plain noise.
  task automatic queue_token();
    int n;
    int r;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        n = $urandom_range(1, 5);
        repeat (n) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      4, 5: begin
        r = $urandom_range(0, 3);
        text_q.push_back(r == 0 ? cclc_pkg::CH_SPACE : r == 1 ? cclc_pkg::CH_TAB :
                         r == 2 ? cclc_pkg::CH_VT : cclc_pkg::CH_FF);
      end
      6, 7: text_q.push_back($urandom_range(0, 1) ? cclc_pkg::CH_SEMI : cclc_pkg::CH_COMMA);
      8, 9: begin
        text_q.push_back(cclc_pkg::CH_DQUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            text_q.push_back(cclc_pkg::CH_BSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
          end else if (r == 1) begin
            text_q.push_back(cclc_pkg::CH_LF);
          end else if (r == 2) begin
            text_q.push_back($urandom_range(0, 1) ? cclc_pkg::CH_SEMI : cclc_pkg::CH_COMMA);
          end else begin
            text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end
        end
        text_q.push_back(cclc_pkg::CH_DQUOTE);
      end
      10: begin
        text_q.push_back(cclc_pkg::CH_SQUOTE);
        if ($urandom_range(0, 2) == 0) begin
          text_q.push_back(cclc_pkg::CH_BSLASH);
          text_q.push_back($urandom_range(0, 1) ? cclc_pkg::CH_SQUOTE : cclc_pkg::CH_LF);
        end else begin
          text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        text_q.push_back(cclc_pkg::CH_SQUOTE);
      end
      11, 12: begin
        text_q.push_back(cclc_pkg::CH_SLASH);
        text_q.push_back(cclc_pkg::CH_STAR);
        n = $urandom_range(0, 8);
        repeat (n) begin
          r = $urandom_range(0, 7);
          text_q.push_back(r == 0 ? cclc_pkg::CH_STAR : r == 1 ? cclc_pkg::CH_SLASH :
                           r == 2 ? cclc_pkg::CH_LF : r == 3 ? cclc_pkg::CH_DQUOTE :
                           8'($urandom_range(8'h20, 8'h7E)));
        end
        repeat ($urandom_range(1, 3)) text_q.push_back(cclc_pkg::CH_STAR);
        text_q.push_back(cclc_pkg::CH_SLASH);
      end
      13: begin
        text_q.push_back(cclc_pkg::CH_SLASH);
        text_q.push_back(cclc_pkg::CH_SLASH);
        n = $urandom_range(0, 6);
        repeat (n) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        text_q.push_back(cclc_pkg::CH_LF);
      end
      14, 15: begin
        if ($urandom_range(0, 2) == 0)
          text_q.push_back(cclc_pkg::CH_CR);
        text_q.push_back(cclc_pkg::CH_LF);
      end
      16: begin
        text_q.push_back(cclc_pkg::CH_SLASH);
        r = $urandom_range(0, 4);
        text_q.push_back(r == 0 ? cclc_pkg::CH_DQUOTE : r == 1 ? cclc_pkg::CH_BSLASH :
                         r == 2 ? cclc_pkg::CH_LF : r == 3 ? cclc_pkg::CH_SQUOTE :
                         8'($urandom_range(8'h61, 8'h7A)));
      end
      17: begin
        text_q.push_back(cclc_pkg::CH_BSLASH);
        r = $urandom_range(0, 3);
        text_q.push_back(r == 0 ? cclc_pkg::CH_LF : r == 1 ? cclc_pkg::CH_CR :
                         8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Random source text in chunks: idling varies per chunk, the enable is
  // rewritten between some of them, one chunk runs against a long receiver
  // hold, some wait for every result first, and the last chunks run flat out.
  task automatic test_random_source();
    for (int k = 0; k < RAND_CHUNKS; k++) begin
      idle_on = (k < RAND_CHUNKS - 3) && (k % 3 != 2);
      if (k % 4 == 0) begin
        wait_all_results();
        write_sep_enable(1'($urandom_range(0, 1)));
      end
      if (k == 5)
        long_hold_req = 1'b1;
      if (k == 6)
        wait_all_results();
      for (int i = 0; i < CHUNK_LEN; i++) begin
        if (text_q.size() == 0)
          queue_token();
        send_byte(text_q.pop_front(), $urandom_range(0, 299) == 0);
      end
    end
    idle_on = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    clear_lex();
    sep_enable = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_separator_enable();
    test_line_totals();
    test_random_source();
    wait_all_results();

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
